// ===== hdl/fgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_pkg
// Shared constants and types for the greedy collection occupancy model.
// ----------------------------------------------------------------------------
package fgc_pkg;

  localparam int UNITS_PER_BLOCK  = 8;
  localparam int BLOCK_COUNT_LOG2 = 25;
  localparam int NBINS            = UNITS_PER_BLOCK + 1;
  localparam int BIN_W            = $clog2(NBINS);
  localparam int COUNT_W          = BLOCK_COUNT_LOG2 + 1;
  localparam int WEIGHT_W         = COUNT_W + BIN_W;
  localparam int PICK_W           = 28;
  localparam int PEND_W           = 4;
  localparam int CFG_W            = 26;
  localparam int CFG_IDX_W        = 1;
  localparam int FAULT_W          = 2;
  localparam int IN_TDATA_W       = 32;
  localparam int OUT_TDATA_W      = 48;

  localparam logic [BIN_W-1:0]   FULL_BIN = BIN_W'(UNITS_PER_BLOCK);
  localparam logic [BIN_W-1:0]   ONE_FREE_BIN = BIN_W'(UNITS_PER_BLOCK - 1);
  localparam logic [CFG_W-1:0]   RST_FULL_BLOCKS = CFG_W'(8388608);
  localparam logic [CFG_W-1:0]   RST_ONE_FREE_BLOCKS = CFG_W'(25165824);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_FULL     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ONE_FREE = 1'b1;

  // Input command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DRAW    = 1'b1;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_OK      = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_NO_FREE = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVERRUN = 2'd2;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOW,
    OP_FULL,
    OP_DRAW,
    OP_BELOW,
    OP_EMIT
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic val_nz;     // bin under the scan index is nonempty
    logic idx_last;   // scan index is at the full bin
    logic hit;        // remaining pick falls inside the current bin weight
    logic pend_zero;  // no invalidations owed
  } dp_status_t;

endpackage

// ===== hdl/fgc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_ctrl
// Sequencer: walks the least-used scan, the full-bin update, the weighted
// scan and the bin-below update, then hands the result to the output beat.
// ----------------------------------------------------------------------------
module fgc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fgc_pkg::dp_status_t st,
  output fgc_pkg::op_t       op
);
  import fgc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOW,
    S_FULL,
    S_DRAW,
    S_BELOW,
    S_FINISH
  } state_t;

  state_t state;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_FINISH) && (!out_valid || out_ready);

  // Operation for the current step
  always_comb begin
    case (state)
      S_IDLE:   op = (in_valid) ? OP_ACCEPT : OP_NONE;
      S_LOW:    op = OP_LOW;
      S_FULL:   op = OP_FULL;
      S_DRAW:   op = OP_DRAW;
      S_BELOW:  op = OP_BELOW;
      S_FINISH: op = (emit) ? OP_EMIT : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_cmd == CMD_RESTART) state <= S_FINISH;
            else if (st.pend_zero)     state <= S_LOW;
            else                       state <= S_DRAW;
          end
        end
        S_LOW: begin
          if (st.val_nz) state <= (st.idx_last) ? S_FINISH : S_FULL;
          else if (st.idx_last) state <= S_FINISH;
        end
        S_FULL: state <= S_DRAW;
        S_DRAW: begin
          if (st.hit) state <= S_BELOW;
          else if (st.idx_last) state <= S_FINISH;
        end
        S_BELOW: state <= S_FINISH;
        S_FINISH: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/fgc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_datapath
// Histogram bins, pending count, config registers, one bin read per cycle,
// weight multiply and prefix subtract, result and output registers.
// ----------------------------------------------------------------------------
module fgc_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fgc_pkg::op_t                     op,
  output fgc_pkg::dp_status_t              st,
  input  logic                             in_cmd,
  input  logic [fgc_pkg::PICK_W-1:0]       in_pick,
  input  logic                             wr_en,
  input  logic [fgc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [fgc_pkg::CFG_W-1:0]        wr_data,
  output logic [fgc_pkg::OUT_TDATA_W-1:0]  out_data
);
  import fgc_pkg::*;

  logic [COUNT_W-1:0]  hist [NBINS];
  logic [PEND_W-1:0]   pending;
  logic [CFG_W-1:0]    init_full;
  logic [CFG_W-1:0]    init_one_free;
  logic [BIN_W-1:0]    idx;
  logic [PICK_W-1:0]   rest;

  // Result fields of the item at work
  logic                started;
  logic [BIN_W-1:0]    lfill;
  logic [COUNT_W-1:0]  lblocks;
  logic [BIN_W-1:0]    hit_fill;
  logic [FAULT_W-1:0]  fault;

  logic [COUNT_W-1:0]  val;
  logic [WEIGHT_W-1:0] weight;
  logic                hit;

  // Single read port on the scan index
  always_comb begin
    val = (idx <= FULL_BIN) ? hist[idx] : '0;
  end

  assign weight = {{BIN_W{1'b0}}, val} * {{COUNT_W{1'b0}}, idx};
  assign hit    = {{(WEIGHT_W-PICK_W){1'b0}}, rest} < weight;

  assign st.val_nz    = (val != '0);
  assign st.idx_last  = (idx == FULL_BIN);
  assign st.hit       = hit;
  assign st.pend_zero = (pending == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NBINS; b++) begin
        if (BIN_W'(b) == FULL_BIN) hist[b] <= COUNT_W'(RST_FULL_BLOCKS);
        else if (BIN_W'(b) == ONE_FREE_BIN) hist[b] <= COUNT_W'(RST_ONE_FREE_BLOCKS);
        else hist[b] <= '0;
      end
      pending            <= '0;
      init_full          <= RST_FULL_BLOCKS;
      init_one_free      <= RST_ONE_FREE_BLOCKS;
    end else begin
      // Config writes
      if (wr_en) begin
        if (wr_index == REG_INIT_FULL) init_full <= wr_data;
        if (wr_index == REG_INIT_ONE_FREE) init_one_free <= wr_data;
      end
      case (op)
        OP_ACCEPT: begin
          rest     <= in_pick;
          started  <= 1'b0;
          lfill    <= '0;
          lblocks  <= '0;
          hit_fill <= '0;
          fault    <= FAULT_OK;
          idx      <= (pending == '0) ? '0 : BIN_W'(1);
          if (in_cmd == CMD_RESTART) begin
            for (int b = 0; b < NBINS; b++) begin
              if (BIN_W'(b) == FULL_BIN) hist[b] <= COUNT_W'(init_full);
              else if (BIN_W'(b) == ONE_FREE_BIN) hist[b] <= COUNT_W'(init_one_free);
              else hist[b] <= '0;
            end
            pending            <= '0;
          end
        end
        // Least-used search, one bin a cycle
        OP_LOW: begin
          if (val != '0) begin
            lfill   <= idx;
            lblocks <= val;
            if (idx == FULL_BIN) begin
              fault <= FAULT_NO_FREE;
            end else begin
              started   <= 1'b1;
              hist[idx] <= val - COUNT_W'(1);
              pending   <= PEND_W'(FULL_BIN - idx);
              idx       <= FULL_BIN;
            end
          end else if (idx == FULL_BIN) begin
            fault <= FAULT_NO_FREE;
          end else begin
            idx <= idx + BIN_W'(1);
          end
        end
        // Collected block lands in the full bin
        OP_FULL: begin
          hist[idx] <= val + COUNT_W'(1);
          idx       <= BIN_W'(1);
        end
        // Weighted prefix scan over fills 1 .. full
        OP_DRAW: begin
          if (hit) begin
            hit_fill  <= idx;
            hist[idx] <= val - COUNT_W'(1);
            idx       <= idx - BIN_W'(1);
            if (pending != '0) pending <= pending - PEND_W'(1);
          end else begin
            rest <= rest - weight[PICK_W-1:0];
            if (idx == FULL_BIN) fault <= FAULT_OVERRUN;
            else idx <= idx + BIN_W'(1);
          end
        end
        OP_BELOW: begin
          hist[idx] <= val + COUNT_W'(1);
        end
        OP_EMIT: begin
          out_data <= {{(OUT_TDATA_W-41){1'b0}}, fault, pending, hit_fill,
                       lblocks, lfill, started};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/flash_greedy_gc_occupancy_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_greedy_gc_occupancy_model
// Histogram of flash blocks by valid units with greedy collection rounds and
// weighted invalidation draws.
// ----------------------------------------------------------------------------
//  channel   signals                            role
//  s_*       s_tvalid s_tready s_tdata s_tuser  restart / draw items in
//  m_*       m_tvalid m_tready m_tdata          one result beat per item
//  wr_*      wr_en wr_index wr_data             init register writes
//
//  A restart goes from accept straight to the result. A draw runs, between
//  accept and result, a least-used scan from fill 0 upward when a round starts
//  (up to the full bin when no bin below full is filled, which ends the item),
//  the full-bin update, the weighted scan over fills 1 to 8 (one histogram bin
//  read per cycle) and the bin-below update.
//  Reset (rst, synchronous) loads bin 8 = 8388608, bin 7 = 25165824.
//  A new item is taken while the previous result waits on m_tready; work
//  stalls only when a finished result finds the output register still full.
module flash_greedy_gc_occupancy_model (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fgc_pkg::IN_TDATA_W-1:0]   s_tdata,   // [27:0] unit_pick
  input  logic [0:0]                       s_tuser,   // [0] cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] round_started, [4:1] least_used_fill, [30:5] least_used_blocks,
  // [34:31] hit_fill, [38:35] pending_after, [40:39] fault
  output logic [fgc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             wr_en,
  input  logic [fgc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [fgc_pkg::CFG_W-1:0]        wr_data
);
  import fgc_pkg::*;

  op_t        op;
  dp_status_t st;

  fgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .op        (op)
  );

  fgc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .st       (st),
    .in_cmd   (s_tuser[0]),
    .in_pick  (s_tdata[PICK_W-1:0]),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .out_data (m_tdata)
  );

endmodule

// ===== hdl/fgc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module fgc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import fgc_pkg::*;

  // Stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A round only starts from a bin below full
  a_round: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[4:1] < FULL_BIN)
    else $error("round started from the full bin");

  // A chosen bin means no fault
  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34:31] != 4'd0 |-> m_tdata[40:39] == FAULT_OK)
    else $error("hit reported with a fault");

  // A no-free fault never comes with a started round or pending invalidations
  a_nofree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40:39] == FAULT_NO_FREE |-> !m_tdata[0] && m_tdata[38:35] == 4'd0)
    else $error("no-free fault with round or pending");

endmodule

bind flash_greedy_gc_occupancy_model fgc_checker u_fgc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
